// ===== design/tcld_pkg.sv =====
// ----------------------------------------------------------------------------
// tcld_pkg
// Shared types, character codes and helpers for the cooked line discipline.
// ----------------------------------------------------------------------------
`default_nettype none

package tcld_pkg;

    // column counter width (wraps at 2**COLUMN_BITS)
    localparam int COLUMN_BITS = 8;

    // widest expansion: form feed, 25 line feeds
    localparam int FF_LINES = 25;
    localparam int CNT_BITS = $clog2(FF_LINES + 1);

    // input selector / result kind
    localparam logic ACT_HOST  = 1'b0;
    localparam logic ACT_LINE  = 1'b1;
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DLV  = 1'b1;

    // configuration register indexes
    localparam logic CFG_RAW_MODE    = 1'b0;
    localparam logic CFG_WRAP_COLUMN = 1'b1;

    localparam logic [7:0] WRAP_COLUMN_RST = 8'd79;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_EOT   = 8'h04;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_CTRLO = 8'h0F;
    localparam logic [7:0] CH_XON   = 8'h11;
    localparam logic [7:0] CH_XOFF  = 8'h13;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // shape of a transmit burst
    typedef enum logic [1:0] {
        SEQ_PLAIN,   // one byte repeated
        SEQ_BS,      // BS space BS
        SEQ_CRLF     // CR LF
    } t_seq;

    // byte of a burst, picked by the count of bytes still to go
    function automatic logic [7:0] seq_byte(input t_seq s, input logic [CNT_BITS-1:0] n,
                                            input logic [7:0] b);
        logic [7:0] r;
        case (s)
            SEQ_BS:   r = (n == CNT_BITS'(2)) ? CH_SPACE : CH_BS;
            SEQ_CRLF: r = (n == CNT_BITS'(2)) ? CH_CR : CH_LF;
            default:  r = b;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/tty_cooked_line_discipline.sv =====
// ----------------------------------------------------------------------------
// tty_cooked_line_discipline
// Console line discipline: cooks host writes, runs XON/XOFF and mute on
// received bytes, echoes and delivers received bytes.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  s         in         i_s_tvalid/o_s_tready  tuser: action, tdata: data
//  m         out        o_m_tvalid/i_m_tready  tuser: kind, tdata: byte/hold/muted,
//                                              tlast: last
//  cfg       in         i_cfg_valid/o_cfg_ready index 0 raw_mode, 1 wrap_column
//
//  An input beat is decoded in the cycle it is accepted: flags and column are
//  updated at that edge and the burst it causes is loaded into a job register.
//  The job register feeds one result beat per cycle into the output register
//  while the output is not stalled; the next input beat is taken in the cycle
//  the last result of the current job moves to the output register. Items with
//  no result leave the job register empty, so the input stays ready.
//  Reset (synchronous, active low) clears flags, column, job and output valid
//  and loads the configuration reset values. A stalled output holds its beat
//  and the job register waits behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module tty_cooked_line_discipline (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input stream
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] data
    input  wire logic       i_s_tuser,   // [0] action
    // result stream
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [15:0]     o_m_tdata,   // [7:0] byte_out, [8] hold, [9] muted, rest 0
    output logic            o_m_tuser,   // [0] kind
    output logic            o_m_tlast,   // last
    // configuration writes
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    localparam int CB = tcld_pkg::COLUMN_BITS;
    localparam int NB = tcld_pkg::CNT_BITS;

    // configuration
    logic                 r_raw;
    logic [7:0]           r_wrap;

    // line state
    logic                 r_hold;
    logic                 r_mute;
    logic [CB-1:0]        r_col;

    // job register: pending burst of transmit bytes, then an optional delivery
    logic [NB-1:0]        r_txn;
    tcld_pkg::t_seq       r_seq;
    logic [7:0]           r_txb;
    logic                 r_dlv;
    logic [7:0]           r_dlv_byte;
    logic                 r_res_hold;
    logic                 r_res_mute;

    // output register
    logic                 r_out_valid;
    logic                 r_out_kind;
    logic [7:0]           r_out_byte;
    logic                 r_out_hold;
    logic                 r_out_mute;
    logic                 r_out_last;

    // decode of the incoming beat
    logic                 s_acc;
    logic [7:0]           ch;
    logic                 n_hold;
    logic                 n_mute;
    logic [CB-1:0]        n_col;
    tcld_pkg::t_seq       p_seq;
    logic [NB-1:0]        p_n;
    logic [7:0]           p_txb;
    logic                 p_dlv;
    logic                 do_cook;

    // emission
    logic                 job_valid;
    logic                 job_last;
    logic                 emit_go;

    assign o_cfg_ready = 1'b1;
    assign s_acc       = i_s_tvalid && o_s_tready;

    // received bytes lose bit 7 unless raw
    assign ch = (i_s_tuser == tcld_pkg::ACT_LINE && !r_raw) ? {1'b0, i_s_tdata[6:0]}
                                                           : i_s_tdata;

    always_comb begin
        n_hold  = r_hold;
        n_mute  = r_mute;
        n_col   = r_col;
        p_seq   = tcld_pkg::SEQ_PLAIN;
        p_n     = '0;
        p_txb   = ch;
        p_dlv   = 1'b0;
        do_cook = 1'b0;

        if (i_s_tuser == tcld_pkg::ACT_HOST) begin
            if (r_raw) begin
                p_n   = NB'(1);
                p_txb = i_s_tdata;
            end else begin
                do_cook = 1'b1;
            end
        end else if (r_hold) begin
            // held: only XON gets through
            if (i_s_tdata == tcld_pkg::CH_XON) begin
                n_hold = 1'b0;
            end
        end else if (i_s_tdata == tcld_pkg::CH_XOFF) begin
            n_hold = 1'b1;
        end else if (i_s_tdata == tcld_pkg::CH_XON) begin
            n_hold = 1'b0;
        end else if (i_s_tdata == tcld_pkg::CH_CTRLO) begin
            n_mute = !r_mute;
        end else if (i_s_tdata != tcld_pkg::CH_NUL) begin
            if (ch == tcld_pkg::CH_CTRLO) begin
                n_mute = !r_mute;
            end else if (ch != tcld_pkg::CH_NUL) begin
                do_cook = 1'b1;
                p_dlv   = 1'b1;
            end
        end

        if (do_cook) begin
            case (ch)
                tcld_pkg::CH_NUL, tcld_pkg::CH_EOT: begin
                end
                tcld_pkg::CH_BS: begin
                    p_seq = tcld_pkg::SEQ_BS;
                    p_n   = NB'(3);
                    n_col = (r_col == '0) ? CB'(r_wrap) : r_col - CB'(1);
                end
                tcld_pkg::CH_TAB: begin
                    p_txb = tcld_pkg::CH_SPACE;
                    p_n   = NB'(3'd4 - {1'b0, r_col[1:0]});
                    n_col = {r_col[CB-1:2] + (CB-2)'(1), 2'b00};
                end
                tcld_pkg::CH_FF: begin
                    p_txb = tcld_pkg::CH_LF;
                    p_n   = NB'(tcld_pkg::FF_LINES);
                end
                tcld_pkg::CH_CR: begin
                    p_n   = NB'(1);
                    n_col = '0;
                end
                tcld_pkg::CH_LF: begin
                    p_seq = tcld_pkg::SEQ_CRLF;
                    p_n   = NB'(2);
                    n_col = '0;
                end
                tcld_pkg::CH_CTRLO: begin
                    n_mute = 1'b0;
                end
                default: begin
                    p_n   = NB'(1);
                    n_col = r_col + CB'(1);
                end
            endcase
        end

        // muted: the column moves but nothing is sent
        if (r_mute) begin
            p_n = '0;
        end
    end

    // job drains one beat per cycle into the output register while the output is not stalled
    assign job_valid  = (r_txn != '0) || r_dlv;
    assign job_last   = ((r_txn == NB'(1)) && !r_dlv) || ((r_txn == '0) && r_dlv);
    assign emit_go    = job_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !job_valid || (emit_go && job_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw  <= 1'b0;
            r_wrap <= tcld_pkg::WRAP_COLUMN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tcld_pkg::CFG_RAW_MODE:    r_raw  <= i_cfg_data[0];
                tcld_pkg::CFG_WRAP_COLUMN: r_wrap <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
            r_mute <= 1'b0;
            r_col  <= '0;
            r_txn  <= '0;
            r_dlv  <= 1'b0;
            r_seq  <= tcld_pkg::SEQ_PLAIN;
        end else if (s_acc) begin
            r_hold     <= n_hold;
            r_mute     <= n_mute;
            r_col      <= n_col;
            r_txn      <= p_n;
            r_seq      <= p_seq;
            r_dlv      <= p_dlv;
        end else if (emit_go) begin
            if (r_txn != '0) begin
                r_txn <= r_txn - NB'(1);
            end else begin
                r_dlv <= 1'b0;
            end
        end
    end

    // job payload
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_txb      <= p_txb;
            r_dlv_byte <= ch;
            r_res_hold <= n_hold;
            r_res_mute <= n_mute;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out_kind <= (r_txn != '0) ? tcld_pkg::KIND_TX : tcld_pkg::KIND_DLV;
            r_out_byte <= (r_txn != '0) ? tcld_pkg::seq_byte(r_seq, r_txn, r_txb)
                                        : r_dlv_byte;
            r_out_hold <= r_res_hold;
            r_out_mute <= r_res_mute;
            r_out_last <= job_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {6'b0, r_out_mute, r_out_hold, r_out_byte};
    assign o_m_tlast  = r_out_last;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // input stays blocked while the job has more than its final beat to send
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_txn > NB'(1)) || ((r_txn != '0) && r_dlv)) |-> !o_s_tready)
        else $error("input accepted with a burst still in flight");

    // an empty job never blocks the input
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !job_valid |-> o_s_tready)
        else $error("input blocked with no job pending");

    // a delivery is always the final beat of its item
    a_dlv_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == tcld_pkg::KIND_DLV)) |-> o_m_tlast)
        else $error("delivery beat without last");

    // bytes received while held are dropped without a result
    a_held_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (i_s_tuser == tcld_pkg::ACT_LINE) && r_hold) |=> !job_valid)
        else $error("held receive produced a result");

    // burst never exceeds the form feed expansion
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_txn <= NB'(tcld_pkg::FF_LINES))
        else $error("burst count out of range");

endmodule

`default_nettype wire
